// ===== design/fcr_pkg.sv =====
package fcr_pkg;

    localparam int SIZE_W  = 7;
    localparam int COORD_W = 8;
    localparam int DIM_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 13;
    localparam int INDEX_W = 12;
    localparam int CFG_W   = 1;

    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] FRAME_RESET = 7'd64;

    typedef struct packed {
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } fill_item_t;

    typedef struct packed {
        logic              draw;
        logic [SIZE_W-1:0] x;
        logic [SIZE_W-1:0] y;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } rect_t;

    typedef struct packed {
        logic wr_en;
        logic done;
    } fill_sts_t;

endpackage

// ===== design/fcr_store.sv =====
module fcr_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [fcr_pkg::WORD_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [fcr_pkg::WORD_W-1:0]  rdata
);
    import fcr_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/fcr_clip.sv =====
module fcr_clip (
    input  logic                        aclk,
    input  fcr_pkg::fill_item_t         item,
    input  logic [fcr_pkg::SIZE_W-1:0]  fw,
    input  logic [fcr_pkg::SIZE_W-1:0]  fh,
    output fcr_pkg::rect_t              rect
);
    import fcr_pkg::*;

    logic signed [9:0] xs, ys, ws, hs, fws, fhs;
    logic signed [9:0] x1, y1, w1, h1, room_x, room_y, w2, h2;
    logic              off, empty;
    rect_t             rect_reg;

    always_comb begin
        xs  = {{2{item.x_pos[COORD_W-1]}}, item.x_pos};
        ys  = {{2{item.y_pos[COORD_W-1]}}, item.y_pos};
        ws  = {2'b00, item.w};
        hs  = {2'b00, item.h};
        fws = {3'b000, fw};
        fhs = {3'b000, fh};
        off = (xs >= fws) || (ys >= fhs);
        if (xs[9]) begin
            w1 = ws + xs;
            x1 = 10'sd0;
        end else begin
            w1 = ws;
            x1 = xs;
        end
        if (ys[9]) begin
            h1 = hs + ys;
            y1 = 10'sd0;
        end else begin
            h1 = hs;
            y1 = ys;
        end
        empty  = off || (w1 <= 10'sd0) || (h1 <= 10'sd0);
        room_x = fws - x1;
        room_y = fhs - y1;
        w2     = (w1 > room_x) ? room_x : w1;
        h2     = (h1 > room_y) ? room_y : h1;
    end

    always_ff @(posedge aclk) begin
        rect_reg.draw <= !empty;
        rect_reg.x    <= x1[SIZE_W-1:0];
        rect_reg.y    <= y1[SIZE_W-1:0];
        rect_reg.w    <= w2[SIZE_W-1:0];
        rect_reg.h    <= h2[SIZE_W-1:0];
    end

    assign rect = rect_reg;

endmodule

// ===== design/fcr_fill.sv =====
module fcr_fill #(
    parameter int AW = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  fcr_pkg::rect_t              rect,
    input  logic [fcr_pkg::SIZE_W-1:0]  fw,
    input  logic [fcr_pkg::SIZE_W-1:0]  fh,
    output logic [AW-1:0]               waddr,
    output logic [fcr_pkg::COUNT_W-1:0] count,
    output fcr_pkg::fill_sts_t          sts
);
    import fcr_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_BASE = 2'd1;
    localparam logic [1:0] F_RUN  = 2'd2;

    logic [1:0]            state_reg;
    logic                  done_reg;
    logic [2*SIZE_W-1:0]   prod_reg;
    logic [AW-1:0]         addr_reg, row_base_reg;
    logic [SIZE_W-1:0]     col_reg, row_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [SIZE_W-1:0]     rows_above;
    logic [31:0]           base_sum, next_row;

    always_comb begin
        rows_above = fh - 7'd1 - rect.y;
        base_sum   = 32'(prod_reg) + 32'(rect.x);
        next_row   = 32'(row_base_reg) - 32'(fw);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                F_IDLE: begin
                    if (start) begin
                        state_reg <= F_BASE;
                    end
                end
                F_BASE: begin
                    state_reg <= F_RUN;
                end
                F_RUN: begin
                    if (col_reg == 7'd1 && row_reg == 7'd1) begin
                        state_reg <= F_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                prod_reg  <= (2*SIZE_W)'(rows_above) * (2*SIZE_W)'(fw);
                col_reg   <= rect.w;
                row_reg   <= rect.h;
                count_reg <= '0;
            end
            F_BASE: begin
                addr_reg     <= base_sum[AW-1:0];
                row_base_reg <= base_sum[AW-1:0];
            end
            F_RUN: begin
                count_reg <= count_reg + 13'd1;
                if (col_reg == 7'd1) begin
                    addr_reg     <= next_row[AW-1:0];
                    row_base_reg <= next_row[AW-1:0];
                    col_reg      <= rect.w;
                    row_reg      <= row_reg - 7'd1;
                end else begin
                    addr_reg <= addr_reg + AW'(1);
                    col_reg  <= col_reg - 7'd1;
                end
            end
            default: begin
                count_reg <= count_reg;
            end
        endcase
    end

    assign waddr     = addr_reg;
    assign count     = count_reg;
    assign sts.wr_en = (state_reg == F_RUN);
    assign sts.done  = done_reg;

endmodule

// ===== design/clipped_rectangle_fill.sv =====
// Frame store of MAX_WIDTH x MAX_HEIGHT 32-bit pixel words with rectangle fill and word read.
// After reset the store is swept to zero, one word per cycle over all MAX_WIDTH * MAX_HEIGHT
// words, 4096 by default; s_ready stays low during the sweep, configuration writes are taken.
// Items are worked one at a time. A read goes through one registered memory read, then the
// result register and the output register. A fill goes through clip, address set-up and
// hand-off, then writes its pixels one by one through the single write port of the store; a
// fill that clips away entirely skips the writes. The next item is accepted once the previous
// result sits in the output register, even while it waits to be taken.
module clipped_rectangle_fill #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fcr_pkg::CFG_W-1:0]          cfg_index,
    input  logic [fcr_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic signed [fcr_pkg::COORD_W-1:0] s_x_pos,
    input  logic signed [fcr_pkg::COORD_W-1:0] s_y_pos,
    input  logic [fcr_pkg::DIM_W-1:0]          s_rect_width,
    input  logic [fcr_pkg::DIM_W-1:0]          s_rect_height,
    input  logic [fcr_pkg::WORD_W-1:0]         s_packed_colour,
    input  logic [fcr_pkg::CHAN_W-1:0]         s_chan_alpha,
    input  logic [fcr_pkg::CHAN_W-1:0]         s_chan_red,
    input  logic [fcr_pkg::CHAN_W-1:0]         s_chan_green,
    input  logic [fcr_pkg::CHAN_W-1:0]         s_chan_blue,
    input  logic [fcr_pkg::INDEX_W-1:0]        s_read_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fcr_pkg::WORD_W-1:0]         m_read_word,
    output logic [fcr_pkg::COUNT_W-1:0]        m_pixels_written
);
    import fcr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CLIP  = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_FILL  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg;
    logic [SIZE_W-1:0]   frame_width_reg, frame_height_reg;
    logic [SIZE_W-1:0]   fw_eff, fh_eff;
    fill_item_t          item_reg;
    logic [WORD_W-1:0]   colour_reg, colour_next;
    logic                in_range_reg;
    logic [WORD_W-1:0]   res_word_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_read_word_reg;
    logic [COUNT_W-1:0]  m_pixels_written_reg;
    logic                s_accept, m_load;
    logic [31:0]         idx_ext;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr, fill_waddr;
    logic [WORD_W-1:0]   mem_wdata, mem_rdata;
    rect_t               rect;
    fill_sts_t           fill_sts;
    logic                fill_start;
    logic [COUNT_W-1:0]  fill_count;

    always_comb begin
        if (frame_width_reg == '0) begin
            fw_eff = 7'd1;
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            fw_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            fw_eff = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            fh_eff = 7'd1;
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            fh_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            fh_eff = frame_height_reg;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_RESET;
            frame_height_reg <= FRAME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: begin
                    frame_width_reg <= frame_width_reg;
                end
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign idx_ext  = 32'(s_read_index);
    assign fill_start = (state_reg == ST_START) && rect.draw;

    always_comb begin
        if (s_packed_colour != '0) begin
            colour_next = s_packed_colour;
        end else begin
            colour_next = {s_chan_alpha, s_chan_red, s_chan_green, s_chan_blue};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_opcode == OP_READ) ? ST_READ : ST_CLIP;
                end
            end
            ST_READ:  state_next = ST_DONE;
            ST_CLIP:  state_next = ST_START;
            ST_START: state_next = rect.draw ? ST_FILL : ST_DONE;
            ST_FILL: begin
                if (fill_sts.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.x_pos <= s_x_pos;
            item_reg.y_pos <= s_y_pos;
            item_reg.w     <= s_rect_width;
            item_reg.h     <= s_rect_height;
            colour_reg     <= colour_next;
            in_range_reg   <= (idx_ext < DEPTH);
        end
        case (state_reg)
            ST_READ: begin
                res_word_reg  <= in_range_reg ? mem_rdata : '0;
                res_count_reg <= '0;
            end
            ST_START: begin
                res_word_reg  <= '0;
                res_count_reg <= '0;
            end
            ST_FILL: begin
                res_count_reg <= fill_count;
            end
            default: begin
                res_word_reg <= res_word_reg;
            end
        endcase
        if (m_load) begin
            m_read_word_reg      <= res_word_reg;
            m_pixels_written_reg <= (state_reg == ST_DONE) ? res_count_reg : '0;
        end
    end

    always_comb begin
        mem_raddr = idx_ext[AW-1:0];
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = fill_sts.wr_en;
            mem_waddr = fill_waddr;
            mem_wdata = colour_reg;
        end
    end

    fcr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fcr_clip u_clip (
        .aclk (aclk),
        .item (item_reg),
        .fw   (fw_eff),
        .fh   (fh_eff),
        .rect (rect)
    );

    fcr_fill #(
        .AW (AW)
    ) u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fill_start),
        .rect    (rect),
        .fw      (fw_eff),
        .fh      (fh_eff),
        .waddr   (fill_waddr),
        .count   (fill_count),
        .sts     (fill_sts)
    );

    assign m_valid          = m_valid_reg;
    assign m_read_word      = m_read_word_reg;
    assign m_pixels_written = m_pixels_written_reg;

endmodule

// ===== design/fcr_checker.sv =====
module fcr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_opcode,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [fcr_pkg::WORD_W-1:0]  m_read_word,
    input logic [fcr_pkg::COUNT_W-1:0] m_pixels_written
);
    import fcr_pkg::*;

    logic [1:0] pend_reg;
    logic       last_op_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            last_op_reg <= s_opcode;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_word) && $stable(m_pixels_written))
        else $error("result word changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("second item taken while one is in work");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result word without an accepted item");

    a_fill_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && pend_reg == 2'd1 && last_op_reg == OP_FILL |-> m_read_word == '0)
        else $error("fill result carries a nonzero read word");

    a_read_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && pend_reg == 2'd1 && last_op_reg == OP_READ |-> m_pixels_written == '0)
        else $error("read result carries a nonzero pixel count");

endmodule

bind clipped_rectangle_fill fcr_checker u_fcr_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_opcode         (s_opcode),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_read_word      (m_read_word),
    .m_pixels_written (m_pixels_written)
);
